/* src/s5rp_pkg.sv */
// Package for the SOCKS5 request parser: parse phases, result kinds, codes
// and the record type of one result entry.
// No dependencies; used by socks5_request_parser_top.
package s5rp_pkg;

  // Parse phases of the greeting and request
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_METHODS = 4'd1,
    PH_VER     = 4'd2,
    PH_CMD     = 4'd3,
    PH_RSV     = 4'd4,
    PH_ATYP    = 4'd5,
    PH_DLEN    = 4'd6,
    PH_ADDR    = 4'd7,
    PH_PORT_HI = 4'd8,
    PH_PORT_LO = 4'd9
  } phase_t;

  // Result kinds
  typedef enum logic [2:0] {
    K_CONSUMED = 3'd0,
    K_REPLY    = 3'd1,
    K_ADDR     = 3'd2,
    K_DONE     = 3'd3,
    K_ERROR    = 3'd4
  } kind_t;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_METHOD   = 2'd1;
  localparam logic [1:0] ERR_VERSION  = 2'd2;
  localparam logic [1:0] ERR_PROTOCOL = 2'd3;

  // Query types
  localparam logic [2:0] QT_CONNECT = 3'd0;
  localparam logic [2:0] QT_BIND    = 3'd1;
  localparam logic [2:0] QT_UDP     = 3'd2;
  localparam logic [2:0] QT_RESOLVE = 3'd3;
  localparam logic [2:0] QT_REVRES  = 3'd4;

  // Address kinds
  localparam logic [1:0] AK_IPV4   = 2'd0;
  localparam logic [1:0] AK_IPV6   = 2'd1;
  localparam logic [1:0] AK_DOMAIN = 2'd2;

  // Protocol bytes
  localparam logic [7:0] SOCKS_VERSION = 8'd5;
  localparam logic [7:0] METHOD_NOAUTH = 8'h00;
  localparam logic [7:0] CMD_CONNECT   = 8'h01;
  localparam logic [7:0] CMD_BIND      = 8'h02;
  localparam logic [7:0] CMD_UDP       = 8'h03;
  localparam logic [7:0] CMD_RESOLVE   = 8'hF0;
  localparam logic [7:0] CMD_REVRES    = 8'hF1;
  localparam logic [7:0] ATYP_IPV4     = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
  localparam logic [7:0] ATYP_IPV6     = 8'h04;
  localparam logic [7:0] IPV4_LEN      = 8'd4;
  localparam logic [7:0] IPV6_LEN      = 8'd16;

  // Configuration register index
  localparam logic REG_EXTENSION_MODE = 1'b0;

  // Result queue depth (room for two results per request plus slack)
  localparam int RESULT_DEPTH = 4;

  // One result entry
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    logic [2:0]  query_type;
    logic [1:0]  address_kind;
    logic [15:0] port;
    logic [1:0]  fault_code;
    logic        last;
  } result_t;

endpackage

/* src/socks5_request_parser_top.sv */
// SOCKS5 client request parser: byte-wise parse of the greeting and request.
// Depends on s5rp_pkg for phases, result kinds, codes and the result record.
//
// Usage:
//   Input stream (s_*): one client byte per request in s_tdata, with s_tuser
//   set on the method-count byte of a new connection, which restarts parsing.
//   Output stream (m_*): one or two results per input byte. m_tuser carries the
//   kind, m_tlast marks the last result of an input byte, and m_tdata carries
//   the reply or address byte, query type, address kind, port and error code.
//   APB port: register 0 (address 0) bit 0 is extension_mode.
// Results: each is written into the result queue when its input byte is taken
// and leaves from the queue head in order. Throughput: one byte per cycle while
// s_tready is high; a byte yielding the two reply bytes takes two entries of the
// four-entry result queue, which lowers s_tready when fewer than two are free.
// Reset (rst, synchronous, active high) empties the result queue, returns the
// parser to idle and clears extension_mode.
// When the receiver stalls, results wait in the queue and s_tready drops once
// it is nearly full; nothing is lost or repeated.
module socks5_request_parser_top (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] start_of_request
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] out_byte, [10:8] query_type,
                                 // [12:11] address_kind, [28:13] port,
                                 // [30:29] fault_code, [31] zero
  output logic [2:0]  m_tuser,   // [2:0] kind
  output logic        m_tlast,   // last
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PTR_W = $clog2(s5rp_pkg::RESULT_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  // Configuration and parse state
  logic                extension_mode;
  s5rp_pkg::phase_t    phase, phase_next;
  logic [7:0]          count_left, count_left_next;
  logic                no_auth_seen, no_auth_seen_next;
  logic [7:0]          command_code, command_code_next;
  logic [1:0]          held_address_kind, held_address_kind_next;
  logic [7:0]          port_high, port_high_next;

  // Results of the current byte
  s5rp_pkg::result_t   res0, res1;
  logic                two_results;

  // Result queue
  s5rp_pkg::result_t   queue [s5rp_pkg::RESULT_DEPTH];
  logic [PTR_W-1:0]    wptr, rptr;
  logic [CNT_W-1:0]    count, count_next;
  logic                accept, pop;
  s5rp_pkg::result_t   head;

  assign accept = s_tvalid && s_tready;
  assign pop    = m_tvalid && m_tready;

  // Configuration register access
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      extension_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == s5rp_pkg::REG_EXTENSION_MODE) begin
      extension_mode <= pwdata[0];
    end
  end
  assign prdata = (paddr[2] == s5rp_pkg::REG_EXTENSION_MODE) ?
                  {31'd0, extension_mode} : 32'd0;

  // Parse step: next state and results for one byte
  always_comb begin
    logic [7:0] b;
    logic [7:0] cnt_dec;
    logic       seen;
    b                      = s_tdata;
    cnt_dec                = count_left - 8'd1;
    seen                   = no_auth_seen || (b == s5rp_pkg::METHOD_NOAUTH);
    phase_next             = phase;
    count_left_next        = count_left;
    no_auth_seen_next      = no_auth_seen;
    command_code_next      = command_code;
    held_address_kind_next = held_address_kind;
    port_high_next         = port_high;
    two_results            = 1'b0;
    res0                   = '0;
    res0.kind              = s5rp_pkg::K_CONSUMED;
    res0.last              = 1'b1;
    res1                   = '0;
    res1.kind              = s5rp_pkg::K_REPLY;
    res1.last              = 1'b1;

    if (s_tuser) begin
      count_left_next   = b;
      no_auth_seen_next = 1'b0;
      phase_next        = (b != 8'd0) ? s5rp_pkg::PH_METHODS : s5rp_pkg::PH_VER;
    end else begin
      case (phase)
        s5rp_pkg::PH_METHODS: begin
          no_auth_seen_next = seen;
          count_left_next   = cnt_dec;
          if (cnt_dec == 8'd0) begin
            if (!seen) begin
              phase_next      = s5rp_pkg::PH_IDLE;
              res0.kind       = s5rp_pkg::K_ERROR;
              res0.fault_code = s5rp_pkg::ERR_METHOD;
            end else begin
              // Reply with version 5, method "no authentication"
              phase_next    = s5rp_pkg::PH_VER;
              two_results   = 1'b1;
              res0.kind     = s5rp_pkg::K_REPLY;
              res0.out_byte = s5rp_pkg::SOCKS_VERSION;
              res0.last     = 1'b0;
            end
          end
        end
        s5rp_pkg::PH_VER: begin
          if (b != s5rp_pkg::SOCKS_VERSION) begin
            phase_next      = s5rp_pkg::PH_IDLE;
            res0.kind       = s5rp_pkg::K_ERROR;
            res0.fault_code = s5rp_pkg::ERR_VERSION;
          end else begin
            phase_next = s5rp_pkg::PH_CMD;
          end
        end
        s5rp_pkg::PH_CMD: begin
          command_code_next = b;
          phase_next        = s5rp_pkg::PH_RSV;
        end
        s5rp_pkg::PH_RSV: begin
          phase_next = s5rp_pkg::PH_ATYP;
        end
        s5rp_pkg::PH_ATYP: begin
          if (b == s5rp_pkg::ATYP_IPV4) begin
            held_address_kind_next = s5rp_pkg::AK_IPV4;
            count_left_next        = s5rp_pkg::IPV4_LEN;
            phase_next             = s5rp_pkg::PH_ADDR;
          end else if (b == s5rp_pkg::ATYP_IPV6) begin
            held_address_kind_next = s5rp_pkg::AK_IPV6;
            count_left_next        = s5rp_pkg::IPV6_LEN;
            phase_next             = s5rp_pkg::PH_ADDR;
          end else if (b == s5rp_pkg::ATYP_DOMAIN) begin
            held_address_kind_next = s5rp_pkg::AK_DOMAIN;
            phase_next             = s5rp_pkg::PH_DLEN;
          end else begin
            phase_next      = s5rp_pkg::PH_IDLE;
            res0.kind       = s5rp_pkg::K_ERROR;
            res0.fault_code = s5rp_pkg::ERR_PROTOCOL;
          end
        end
        s5rp_pkg::PH_DLEN: begin
          count_left_next = b;
          phase_next = (b != 8'd0) ? s5rp_pkg::PH_ADDR : s5rp_pkg::PH_PORT_HI;
        end
        s5rp_pkg::PH_ADDR: begin
          count_left_next = cnt_dec;
          if (cnt_dec == 8'd0) begin
            phase_next = s5rp_pkg::PH_PORT_HI;
          end
          res0.kind         = s5rp_pkg::K_ADDR;
          res0.out_byte     = b;
          res0.address_kind = held_address_kind;
        end
        s5rp_pkg::PH_PORT_HI: begin
          port_high_next = b;
          phase_next     = s5rp_pkg::PH_PORT_LO;
        end
        s5rp_pkg::PH_PORT_LO: begin
          // Classify the command; resolve commands need extension mode
          phase_next        = s5rp_pkg::PH_IDLE;
          res0.kind         = s5rp_pkg::K_DONE;
          res0.address_kind = held_address_kind;
          res0.port         = {port_high, b};
          if (extension_mode && command_code == s5rp_pkg::CMD_RESOLVE) begin
            res0.query_type = s5rp_pkg::QT_RESOLVE;
          end else if (extension_mode && command_code == s5rp_pkg::CMD_REVRES) begin
            res0.query_type = s5rp_pkg::QT_REVRES;
          end else if (command_code == s5rp_pkg::CMD_CONNECT) begin
            res0.query_type = s5rp_pkg::QT_CONNECT;
          end else if (command_code == s5rp_pkg::CMD_BIND) begin
            res0.query_type = s5rp_pkg::QT_BIND;
          end else if (command_code == s5rp_pkg::CMD_UDP) begin
            res0.query_type = s5rp_pkg::QT_UDP;
          end else begin
            res0              = '0;
            res0.kind         = s5rp_pkg::K_ERROR;
            res0.fault_code   = s5rp_pkg::ERR_PROTOCOL;
            res0.last         = 1'b1;
          end
        end
        default: begin
          phase_next = s5rp_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= s5rp_pkg::PH_IDLE;
      count_left        <= 8'd0;
      no_auth_seen      <= 1'b0;
      command_code      <= 8'd0;
      held_address_kind <= 2'd0;
      port_high         <= 8'd0;
    end else if (accept) begin
      phase             <= phase_next;
      count_left        <= count_left_next;
      no_auth_seen      <= no_auth_seen_next;
      command_code      <= command_code_next;
      held_address_kind <= held_address_kind_next;
      port_high         <= port_high_next;
    end
  end

  // Result queue: space for two results is needed before a byte is taken
  assign s_tready = (count <= CNT_W'(s5rp_pkg::RESULT_DEPTH - 2));
  assign m_tvalid = (count != '0);

  always_comb begin
    count_next = count;
    if (accept) begin
      count_next = count_next + (two_results ? CNT_W'(2) : CNT_W'(1));
    end
    if (pop) begin
      count_next = count_next - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (accept) begin
        wptr <= wptr + (two_results ? PTR_W'(2) : PTR_W'(1));
      end
      if (pop) begin
        rptr <= rptr + PTR_W'(1);
      end
    end
  end

  // Queue storage, payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      queue[wptr] <= res0;
      if (two_results) begin
        queue[wptr + PTR_W'(1)] <= res1;
      end
    end
  end

  // Output fields from the queue head
  assign head    = queue[rptr];
  assign m_tuser = head.kind;
  assign m_tlast = head.last;
  assign m_tdata = {1'b0, head.fault_code, head.port, head.address_kind,
                    head.query_type, head.out_byte};

endmodule

/* verif/tb.sv */
// Self-checking testbench for socks5_request_parser_top: a directed table, then
// random greeting and request streams checked against a predictor in this module.
// Depends on s5rp_pkg and socks5_request_parser_top; nothing else is needed.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [2:0] EXT_MODE_ADDR = {s5rp_pkg::REG_EXTENSION_MODE, 2'b00};

  // What a row of the directed table does
  typedef enum logic {
    ROW_BYTE,
    ROW_CONFIG
  } row_op_t;

  // A row either sends one byte or writes extension_mode (value in data).
  // Where typed is set, the single result is given by kind and err.
  typedef struct packed {
    row_op_t         op;
    logic [7:0]      data;
    logic            start;
    logic            typed;
    s5rp_pkg::kind_t kind;
    logic [1:0]      err;
  } row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } stim_t;

  localparam int NUM_ROWS = 30;
  localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // Idle after reset, then a greeting without the no-auth method
    '{ROW_BYTE, 8'hFF, 1'b0, 1'b1, s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, 8'h01, 1'b1, 1'b1, s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, 8'hFE, 1'b0, 1'b1, s5rp_pkg::K_ERROR,    s5rp_pkg::ERR_METHOD},
    // Empty method list, then a bad request version
    '{ROW_BYTE, 8'h00, 1'b1, 1'b1, s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, 8'h04, 1'b0, 1'b1, s5rp_pkg::K_ERROR,    s5rp_pkg::ERR_VERSION},
    // Two methods with no-auth last: reply pair, then resolve while disabled
    '{ROW_BYTE, 8'h02, 1'b1, 1'b1, s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, 8'hFF, 1'b0, 1'b1, s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, s5rp_pkg::METHOD_NOAUTH, 1'b0, 1'b0,
      s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, s5rp_pkg::SOCKS_VERSION, 1'b0, 1'b1,
      s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, s5rp_pkg::CMD_RESOLVE, 1'b0, 1'b1,
      s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, 8'hFF, 1'b0, 1'b1, s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, s5rp_pkg::ATYP_DOMAIN, 1'b0, 1'b1,
      s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b1, s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, 8'hFF, 1'b0, 1'b1, s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b1, s5rp_pkg::K_ERROR,    s5rp_pkg::ERR_PROTOCOL},
    // Address type 2 is refused
    '{ROW_BYTE, 8'h00, 1'b1, 1'b1, s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, s5rp_pkg::SOCKS_VERSION, 1'b0, 1'b1,
      s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, s5rp_pkg::CMD_UDP, 1'b0, 1'b1,
      s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b1, s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, 8'h02, 1'b0, 1'b1, s5rp_pkg::K_ERROR,    s5rp_pkg::ERR_PROTOCOL},
    // Extension mode on: reverse resolve of a one-byte domain
    '{ROW_CONFIG, 8'h01, 1'b0, 1'b0, s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, 8'h00, 1'b1, 1'b1, s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, s5rp_pkg::SOCKS_VERSION, 1'b0, 1'b1,
      s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, s5rp_pkg::CMD_REVRES, 1'b0, 1'b1,
      s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, 8'h7F, 1'b0, 1'b1, s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, s5rp_pkg::ATYP_DOMAIN, 1'b0, 1'b1,
      s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, 8'h01, 1'b0, 1'b1, s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, 8'h80, 1'b0, 1'b0, s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b1, s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE},
    '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] data_byte
  logic        s_tuser = 1'b0;   // [0] start_of_request
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;          // [7:0] out_byte, [10:8] query_type,
                                 // [12:11] address_kind, [28:13] port,
                                 // [30:29] fault_code, [31] zero
  logic [2:0]  m_tuser;          // [2:0] kind
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state
  s5rp_pkg::phase_t  parse_phase = s5rp_pkg::PH_IDLE;
  logic [7:0]        bytes_left = 8'd0;
  logic              noauth_offered = 1'b0;
  logic [7:0]        held_cmd = 8'd0;
  logic [1:0]        held_addr_kind = 2'd0;
  logic [7:0]        port_hi_byte = 8'd0;
  logic              ext_mode = 1'b0;
  s5rp_pkg::result_t step_out [2];

  s5rp_pkg::result_t expected_results [$];
  int                mismatch_count = 0;
  int                cycle_count = 0;
  int                sent_requests = 0;
  int                send_idle_pct = 20;
  int                recv_idle_pct = 49;

  socks5_request_parser_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time,
               expected_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver stalls at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic s5rp_pkg::result_t make_result(s5rp_pkg::kind_t k, logic [7:0] ob,
                                                    logic [2:0] qt, logic [1:0] ak,
                                                    logic [15:0] pt, logic [1:0] ec,
                                                    logic lst);
    s5rp_pkg::result_t r;
    r.kind = k;
    r.out_byte = ob;
    r.query_type = qt;
    r.address_kind = ak;
    r.port = pt;
    r.fault_code = ec;
    r.last = lst;
    return r;
  endfunction

  function automatic string fmt_result(s5rp_pkg::result_t r);
    return $sformatf("kind=%0d byte=%02h qt=%0d ak=%0d port=%04h err=%0d last=%0b",
                     r.kind, r.out_byte, r.query_type, r.address_kind, r.port,
                     r.fault_code, r.last);
  endfunction

  // An error drops the parser back to idle
  function automatic int reject_request(logic [1:0] ec);
    parse_phase = s5rp_pkg::PH_IDLE;
    step_out[0] = make_result(s5rp_pkg::K_ERROR, '0, '0, '0, '0, ec, 1'b1);
    return 1;
  endfunction

  // Advances the parser by one byte; fills step_out and returns how many
  // results the byte produces.
  function automatic int step_parser(logic [7:0] b, logic s);
    logic [2:0] qt;
    step_out[0] = make_result(s5rp_pkg::K_CONSUMED, '0, '0, '0, '0,
                              s5rp_pkg::ERR_NONE, 1'b1);
    if (s) begin
      bytes_left = b;
      noauth_offered = 1'b0;
      parse_phase = (b != 8'd0) ? s5rp_pkg::PH_METHODS : s5rp_pkg::PH_VER;
      return 1;
    end
    case (parse_phase)
      s5rp_pkg::PH_METHODS: begin
        if (b == s5rp_pkg::METHOD_NOAUTH) noauth_offered = 1'b1;
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'd0) begin
          if (!noauth_offered) return reject_request(s5rp_pkg::ERR_METHOD);
          parse_phase = s5rp_pkg::PH_VER;
          step_out[0] = make_result(s5rp_pkg::K_REPLY, s5rp_pkg::SOCKS_VERSION, '0, '0, '0,
                                    s5rp_pkg::ERR_NONE, 1'b0);
          step_out[1] = make_result(s5rp_pkg::K_REPLY, s5rp_pkg::METHOD_NOAUTH, '0, '0, '0,
                                    s5rp_pkg::ERR_NONE, 1'b1);
          return 2;
        end
      end
      s5rp_pkg::PH_VER: begin
        if (b != s5rp_pkg::SOCKS_VERSION) return reject_request(s5rp_pkg::ERR_VERSION);
        parse_phase = s5rp_pkg::PH_CMD;
      end
      s5rp_pkg::PH_CMD: begin
        held_cmd = b;
        parse_phase = s5rp_pkg::PH_RSV;
      end
      s5rp_pkg::PH_RSV: parse_phase = s5rp_pkg::PH_ATYP;
      s5rp_pkg::PH_ATYP: begin
        case (b)
          s5rp_pkg::ATYP_IPV4: begin
            held_addr_kind = s5rp_pkg::AK_IPV4;
            bytes_left = s5rp_pkg::IPV4_LEN;
            parse_phase = s5rp_pkg::PH_ADDR;
          end
          s5rp_pkg::ATYP_IPV6: begin
            held_addr_kind = s5rp_pkg::AK_IPV6;
            bytes_left = s5rp_pkg::IPV6_LEN;
            parse_phase = s5rp_pkg::PH_ADDR;
          end
          s5rp_pkg::ATYP_DOMAIN: begin
            held_addr_kind = s5rp_pkg::AK_DOMAIN;
            parse_phase = s5rp_pkg::PH_DLEN;
          end
          default: return reject_request(s5rp_pkg::ERR_PROTOCOL);
        endcase
      end
      s5rp_pkg::PH_DLEN: begin
        bytes_left = b;
        parse_phase = (b != 8'd0) ? s5rp_pkg::PH_ADDR : s5rp_pkg::PH_PORT_HI;
      end
      s5rp_pkg::PH_ADDR: begin
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'd0) parse_phase = s5rp_pkg::PH_PORT_HI;
        step_out[0] = make_result(s5rp_pkg::K_ADDR, b, '0, held_addr_kind, '0,
                                  s5rp_pkg::ERR_NONE, 1'b1);
      end
      s5rp_pkg::PH_PORT_HI: begin
        port_hi_byte = b;
        parse_phase = s5rp_pkg::PH_PORT_LO;
      end
      s5rp_pkg::PH_PORT_LO: begin
        // The extension commands win only when enabled
        if (ext_mode && held_cmd == s5rp_pkg::CMD_RESOLVE) qt = s5rp_pkg::QT_RESOLVE;
        else if (ext_mode && held_cmd == s5rp_pkg::CMD_REVRES) qt = s5rp_pkg::QT_REVRES;
        else if (held_cmd == s5rp_pkg::CMD_CONNECT) qt = s5rp_pkg::QT_CONNECT;
        else if (held_cmd == s5rp_pkg::CMD_BIND) qt = s5rp_pkg::QT_BIND;
        else if (held_cmd == s5rp_pkg::CMD_UDP) qt = s5rp_pkg::QT_UDP;
        else return reject_request(s5rp_pkg::ERR_PROTOCOL);
        parse_phase = s5rp_pkg::PH_IDLE;
        step_out[0] = make_result(s5rp_pkg::K_DONE, '0, qt, held_addr_kind,
                                  {port_hi_byte, b}, s5rp_pkg::ERR_NONE, 1'b1);
      end
      default: parse_phase = s5rp_pkg::PH_IDLE;
    endcase
    return 1;
  endfunction

  // Result checker
  always @(posedge clk) begin : check_results
    s5rp_pkg::result_t got;
    s5rp_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = make_result(s5rp_pkg::kind_t'(m_tuser), m_tdata[7:0], m_tdata[10:8],
                        m_tdata[12:11], m_tdata[28:13], m_tdata[30:29], m_tlast);
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %s", $time,
                 fmt_result(got));
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
            got.query_type !== want.query_type || got.address_kind !== want.address_kind ||
            got.port !== want.port || got.fault_code !== want.fault_code ||
            got.last !== want.last) begin
          $display("%0t: result mismatch: expected %s, got %s", $time,
                   fmt_result(want), fmt_result(got));
          mismatch_count++;
        end
      end
    end
  end

  // Offers one request, with a random gap first, and returns once it is taken
  task automatic send_request(logic [7:0] b, logic s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata <= b;
    s_tuser <= s;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // Sends one byte and queues what it should produce; a typed row overrides
  // the predictor with a single fixed result.
  task automatic feed_byte(logic [7:0] b, logic s, logic typed, s5rp_pkg::kind_t k,
                           logic [1:0] ec);
    int n;
    send_request(b, s);
    sent_requests++;
    n = step_parser(b, s);
    if (typed) begin
      expected_results.push_back(make_result(k, '0, '0, '0, '0, ec, 1'b1));
    end else begin
      for (int i = 0; i < n; i++) expected_results.push_back(step_out[i]);
    end
  endtask

  // Stops sending and waits until every expected result has come out
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: setup, access, then idle with psel low
  task automatic apb_transfer(logic wr, logic [2:0] addr, logic [31:0] wdata,
                              output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_extension_mode();
    logic [31:0] rdata;
    apb_transfer(1'b0, EXT_MODE_ADDR, 32'd0, rdata);
    if (rdata !== 32'(ext_mode)) begin
      $display("%0t: extension_mode read mismatch: expected %08h, got %08h", $time,
               32'(ext_mode), rdata);
      mismatch_count++;
    end
  endtask

  task automatic set_extension_mode(logic v);
    logic [31:0] rdata;
    wait_for_results();
    apb_transfer(1'b1, EXT_MODE_ADDR, 32'(v), rdata);
    ext_mode = v;
    check_extension_mode();
  endtask

  // Builds one connection: greeting, request, address and port, mostly well
  // formed but with random content, then sends it, now and then cut short.
  task automatic send_connection();
    stim_t conn [$];
    int n_methods;
    int noauth_pos;
    int keep;
    logic [7:0] atyp;
    int addr_len;
    n_methods = ($urandom_range(0, 49) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
    noauth_pos = ($urandom_range(0, 9) == 0) ? -1 : $urandom_range(0, 40);
    if (n_methods != 0) noauth_pos = (noauth_pos < 0) ? -1 : noauth_pos % n_methods;
    conn.push_back('{8'(n_methods), 1'b1});
    for (int i = 0; i < n_methods; i++)
      conn.push_back('{(i == noauth_pos) ? s5rp_pkg::METHOD_NOAUTH :
                       8'($urandom_range(0, 255)), 1'b0});
    conn.push_back('{($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) :
                     s5rp_pkg::SOCKS_VERSION, 1'b0});
    case ($urandom_range(0, 6))
      0: conn.push_back('{s5rp_pkg::CMD_CONNECT, 1'b0});
      1: conn.push_back('{s5rp_pkg::CMD_BIND, 1'b0});
      2: conn.push_back('{s5rp_pkg::CMD_UDP, 1'b0});
      3: conn.push_back('{s5rp_pkg::CMD_RESOLVE, 1'b0});
      4: conn.push_back('{s5rp_pkg::CMD_REVRES, 1'b0});
      default: conn.push_back('{8'($urandom_range(0, 255)), 1'b0});
    endcase
    conn.push_back('{8'($urandom_range(0, 255)), 1'b0});
    case ($urandom_range(0, 9))
      0, 1, 2: atyp = s5rp_pkg::ATYP_IPV4;
      3, 4, 5: atyp = s5rp_pkg::ATYP_IPV6;
      6, 7, 8: atyp = s5rp_pkg::ATYP_DOMAIN;
      default: atyp = 8'($urandom_range(0, 255));
    endcase
    conn.push_back('{atyp, 1'b0});
    addr_len = 0;
    if (atyp == s5rp_pkg::ATYP_IPV4) addr_len = s5rp_pkg::IPV4_LEN;
    else if (atyp == s5rp_pkg::ATYP_IPV6) addr_len = s5rp_pkg::IPV6_LEN;
    else if (atyp == s5rp_pkg::ATYP_DOMAIN) begin
      addr_len = $urandom_range(0, 12);
      conn.push_back('{8'(addr_len), 1'b0});
    end
    for (int i = 0; i < addr_len; i++) conn.push_back('{8'($urandom_range(0, 255)), 1'b0});
    conn.push_back('{8'($urandom_range(0, 255)), 1'b0});
    conn.push_back('{8'($urandom_range(0, 255)), 1'b0});
    keep = ($urandom_range(0, 9) == 0) ? $urandom_range(1, conn.size()) : conn.size();
    for (int i = 0; i < keep; i++)
      feed_byte(conn[i].data, conn[i].start, 1'b0, s5rp_pkg::K_CONSUMED,
                s5rp_pkg::ERR_NONE);
  endtask

  task automatic run_random_phase(int send_pct, int recv_pct, int target);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent_requests = 0;
    while (sent_requests < target) begin
      if ($urandom_range(0, 7) == 0) begin
        // Stray bytes, now and then restarting a connection
        repeat ($urandom_range(1, 3))
          feed_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0, 1'b0,
                    s5rp_pkg::K_CONSUMED, s5rp_pkg::ERR_NONE);
      end else begin
        send_connection();
      end
    end
  endtask

  // Main sequence
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_extension_mode();

    // Directed table
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (DIRECTED_ROWS[r].op == ROW_CONFIG) begin
        set_extension_mode(DIRECTED_ROWS[r].data[0]);
      end else begin
        feed_byte(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].start, DIRECTED_ROWS[r].typed,
                  DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].err);
      end
    end

    // Random phases, each under its own idling and extension setting
    run_random_phase(20, 49, 160);
    set_extension_mode(1'b0);
    run_random_phase(49, 20, 160);
    set_extension_mode(1'b1);
    run_random_phase(0, 0, 150);

    wait_for_results();
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
